// ===== hdl/rycc_pkg.sv =====
package rycc_pkg;

    // Format codes held in the two configuration registers
    localparam logic [1:0] FMT_Y     = 2'd0;
    localparam logic [1:0] FMT_YCBCR = 2'd1;
    localparam logic [1:0] FMT_RGB   = 2'd2;
    localparam logic [1:0] FMT_BAD   = 2'd3;

    // Register indexes on the APB port (byte address / 4)
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    // Conversion mode carried down the pipeline
    localparam logic [2:0] MODE_PASS    = 3'd0;  // components unchanged
    localparam logic [2:0] MODE_KEEP_A  = 3'd1;  // first component kept, rest zero
    localparam logic [2:0] MODE_RGB_Y   = 3'd2;
    localparam logic [2:0] MODE_RGB_YCC = 3'd3;
    localparam logic [2:0] MODE_YCC_RGB = 3'd4;

    // Fixed-point coefficients, scale 2^16
    localparam logic [16:0] K_YR  = 17'd19595;
    localparam logic [16:0] K_YG  = 17'd38470;
    localparam logic [16:0] K_YB  = 17'd7471;
    localparam logic [16:0] K_CB  = 17'd36962;
    localparam logic [16:0] K_CR  = 17'd46727;
    localparam logic [16:0] K_RCR = 17'd91881;
    localparam logic [16:0] K_GCB = 17'd22544;
    localparam logic [16:0] K_GCR = 17'd46793;
    localparam logic [16:0] K_BCB = 17'd116129;

    // Offsets
    localparam logic signed [10:0] OFS_R     = 11'sd179;
    localparam logic signed [10:0] OFS_G     = 11'sd135;
    localparam logic signed [10:0] OFS_B     = 11'sd226;
    localparam logic signed [10:0] OFS_CHROM = 11'sd128;

    typedef struct packed {
        logic [2:0] mode;
        logic       status;
    } t_ctrl;

    // Pick the conversion from the source and target formats
    function automatic t_ctrl decode_mode(input logic [1:0] src, input logic [1:0] tgt);
        t_ctrl ctrl;
        ctrl.mode   = MODE_PASS;
        ctrl.status = 1'b0;
        if (src == FMT_BAD || tgt == FMT_BAD) begin
            ctrl.status = 1'b1;
        end else if (src == tgt) begin
            if (src == FMT_Y) begin
                ctrl.mode = MODE_KEEP_A;
            end
        end else if (src == FMT_Y) begin
            ctrl.status = 1'b1;
        end else if (src == FMT_RGB) begin
            ctrl.mode = (tgt == FMT_Y) ? MODE_RGB_Y : MODE_RGB_YCC;
        end else begin
            ctrl.mode = (tgt == FMT_Y) ? MODE_KEEP_A : MODE_YCC_RGB;
        end
        return ctrl;
    endfunction

    // Clip a signed intermediate to 0..255
    function automatic logic [7:0] clip8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/rgb_ycbcr_pixel_converter_top.sv =====
// Per-pixel color-space converter (RGB, YCbCr, grey Y), 16 fraction bits.
//
// Input: a pixel beat is taken at each rising edge with start high and busy
// low. busy is tied low: a new pixel may be offered in every cycle.
// Output: each result sits on o_out_a/b/c, o_out_last and o_status for one
// cycle, flagged by o_valid. o_valid rises once the beat has passed the stage
// registers r1 to r4 and the output register; one pixel per clock.
// The path is five register stages: input capture, coefficient products,
// luma/RGB reconstruction, chroma products, chroma offset and output select.
// The receiver has no back-pressure; results are never held or dropped.
// Configuration: APB registers source_format (0x0) and target_format (0x4),
// 0 grey, 1 YCbCr, 2 RGB. Write them only while no pixel is in flight; the
// formats are sampled when a pixel is accepted.
// Reset (i_rst_n low, synchronous) clears the pipeline valid bits and sets
// source RGB, target YCbCr. Conversions from grey to another format, or with
// code 3, return o_status high with the components unchanged.
module rgb_ycbcr_pixel_converter_top
    import rycc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_comp_a,
    input  logic [7:0]  i_comp_b,
    input  logic [7:0]  i_comp_c,
    input  logic        i_last_pixel,
    // pixel output
    output logic        o_valid,
    output logic [7:0]  o_out_a,
    output logic [7:0]  o_out_b,
    output logic [7:0]  o_out_c,
    output logic        o_out_last,
    output logic        o_status,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [1:0] r_src_fmt;
    logic [1:0] r_tgt_fmt;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_RGB;
            r_tgt_fmt <= FMT_YCBCR;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_SOURCE) begin
                r_src_fmt <= pwdata[1:0];
            end else begin
                r_tgt_fmt <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TARGET) ? {30'd0, r_tgt_fmt} : {30'd0, r_src_fmt};

    // No stall anywhere in the pipeline
    assign busy = 1'b0;

    // ---------------- stage 1: capture beat and mode ----------------
    logic       r1_vld;
    logic [7:0] r1_a, r1_b, r1_c;
    logic       r1_last;
    t_ctrl      r1_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a    <= i_comp_a;
        r1_b    <= i_comp_b;
        r1_c    <= i_comp_c;
        r1_last <= i_last_pixel;
        r1_ctrl <= decode_mode(r_src_fmt, r_tgt_fmt);
    end

    // ---------------- stage 2: coefficient products ----------------
    logic        r2_vld;
    logic [7:0]  r2_a, r2_b, r2_c;
    logic        r2_last;
    t_ctrl       r2_ctrl;
    logic [23:0] r2_luma;
    logic [24:0] r2_pr, r2_pg, r2_pb;
    logic [24:0] w_luma;

    assign w_luma = 25'(K_YR) * 25'(r1_a) + 25'(K_YG) * 25'(r1_b) + 25'(K_YB) * 25'(r1_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_a    <= r1_a;
        r2_b    <= r1_b;
        r2_c    <= r1_c;
        r2_last <= r1_last;
        r2_ctrl <= r1_ctrl;
        r2_luma <= w_luma[23:0];
        r2_pr   <= 25'(K_RCR) * 25'(r1_c);
        r2_pg   <= 25'(K_GCB) * 25'(r1_b) + 25'(K_GCR) * 25'(r1_c);
        r2_pb   <= 25'(K_BCB) * 25'(r1_b);
    end

    // ---------------- stage 3: luma, color differences, RGB ----------------
    logic              r3_vld;
    logic [7:0]        r3_a, r3_b, r3_c;
    logic              r3_last;
    t_ctrl             r3_ctrl;
    logic [7:0]        r3_y;
    logic signed [8:0] r3_db, r3_dr;
    logic [7:0]        r3_r, r3_g, r3_bl;
    logic [7:0]        w_y;
    logic signed [10:0] w_r, w_g, w_b;

    // luma sum never exceeds 255 * 2^16, so no clip is needed
    assign w_y = r2_luma[23:16];
    assign w_r = $signed({3'd0, r2_a}) + $signed({2'd0, r2_pr[24:16]}) - OFS_R;
    assign w_g = $signed({3'd0, r2_a}) - $signed({2'd0, r2_pg[24:16]}) + OFS_G;
    assign w_b = $signed({3'd0, r2_a}) + $signed({2'd0, r2_pb[24:16]}) - OFS_B;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_a    <= r2_a;
        r3_b    <= r2_b;
        r3_c    <= r2_c;
        r3_last <= r2_last;
        r3_ctrl <= r2_ctrl;
        r3_y    <= w_y;
        r3_db   <= $signed({1'b0, r2_c}) - $signed({1'b0, w_y});
        r3_dr   <= $signed({1'b0, r2_a}) - $signed({1'b0, w_y});
        r3_r    <= clip8(w_r);
        r3_g    <= clip8(w_g);
        r3_bl   <= clip8(w_b);
    end

    // ---------------- stage 4: chroma products ----------------
    logic               r4_vld;
    logic [7:0]         r4_a, r4_b, r4_c;
    logic               r4_last;
    t_ctrl              r4_ctrl;
    logic [7:0]         r4_y, r4_r, r4_g, r4_bl;
    logic signed [25:0] r4_pcb, r4_pcr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_a    <= r3_a;
        r4_b    <= r3_b;
        r4_c    <= r3_c;
        r4_last <= r3_last;
        r4_ctrl <= r3_ctrl;
        r4_y    <= r3_y;
        r4_r    <= r3_r;
        r4_g    <= r3_g;
        r4_bl   <= r3_bl;
        r4_pcb  <= $signed({{17{r3_db[8]}}, r3_db}) * $signed({9'd0, K_CB});
        r4_pcr  <= $signed({{17{r3_dr[8]}}, r3_dr}) * $signed({9'd0, K_CR});
    end

    // ---------------- stage 5: chroma offset and output select ----------------
    logic [7:0]         w_cb, w_cr;
    logic [7:0]         n_out_a, n_out_b, n_out_c;
    logic               r_valid;
    logic [7:0]         r_out_a, r_out_b, r_out_c;
    logic               r_out_last, r_status;

    // arithmetic shift by 16 is the top bits of the product
    assign w_cb = clip8($signed({r4_pcb[25], r4_pcb[25:16]}) + OFS_CHROM);
    assign w_cr = clip8($signed({r4_pcr[25], r4_pcr[25:16]}) + OFS_CHROM);

    always_comb begin
        case (r4_ctrl.mode)
            MODE_KEEP_A: begin
                n_out_a = r4_a;
                n_out_b = 8'd0;
                n_out_c = 8'd0;
            end
            MODE_RGB_Y: begin
                n_out_a = r4_y;
                n_out_b = 8'd0;
                n_out_c = 8'd0;
            end
            MODE_RGB_YCC: begin
                n_out_a = r4_y;
                n_out_b = w_cb;
                n_out_c = w_cr;
            end
            MODE_YCC_RGB: begin
                n_out_a = r4_r;
                n_out_b = r4_g;
                n_out_c = r4_bl;
            end
            default: begin
                n_out_a = r4_a;
                n_out_b = r4_b;
                n_out_c = r4_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_a    <= n_out_a;
        r_out_b    <= n_out_b;
        r_out_c    <= n_out_c;
        r_out_last <= r4_last;
        r_status   <= r4_ctrl.status;
    end

    assign o_valid    = r_valid;
    assign o_out_a    = r_out_a;
    assign o_out_b    = r_out_b;
    assign o_out_c    = r_out_c;
    assign o_out_last = r_out_last;
    assign o_status   = r_status;

endmodule

// ===== hdl/rycc_checker.sv =====
module rycc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] i_comp_a,
    input logic [7:0] i_comp_b,
    input logic       i_last_pixel,
    input logic       o_valid,
    input logic [7:0] o_out_a,
    input logic [7:0] o_out_b,
    input logic       o_out_last,
    input logic       o_status
);

    // every accepted beat produces a result
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted beat produced no result");

    // no result without an accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result without accepted beat");

    // last-pixel mark follows its beat
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_last == $past(i_last_pixel, 5)))
        else $error("last-pixel mark mismatch");

    // unsupported conversion leaves components a and b untouched
    a_unsup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            (o_out_a == $past(i_comp_a, 5)) && (o_out_b == $past(i_comp_b, 5)))
        else $error("unsupported beat was modified");

endmodule

bind rgb_ycbcr_pixel_converter_top rycc_checker u_rycc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_comp_a     (i_comp_a),
    .i_comp_b     (i_comp_b),
    .i_last_pixel (i_last_pixel),
    .o_valid      (o_valid),
    .o_out_a      (o_out_a),
    .o_out_b      (o_out_b),
    .o_out_last   (o_out_last),
    .o_status     (o_status)
);

// ===== tb/rgb_ycbcr_pixel_converter_top_test.sv =====
module rgb_ycbcr_pixel_converter_top_test;
    import rycc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Byte addresses of the two format registers
    localparam logic [2:0] ADDR_SRC = {REG_SOURCE, 2'b00};
    localparam logic [2:0] ADDR_TGT = {REG_TARGET, 2'b00};

    typedef struct {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       last;
        int         gap;
    } t_pixel_in;

    typedef struct {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       last;
        logic       status;
    } t_pixel_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_comp_a = 8'd0;
    logic [7:0]  i_comp_b = 8'd0;
    logic [7:0]  i_comp_c = 8'd0;
    logic        i_last_pixel = 1'b0;
    logic        o_valid;
    logic [7:0]  o_out_a;
    logic [7:0]  o_out_b;
    logic [7:0]  o_out_c;
    logic        o_out_last;
    logic        o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rgb_ycbcr_pixel_converter_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_comp_a     (i_comp_a),
        .i_comp_b     (i_comp_b),
        .i_comp_c     (i_comp_c),
        .i_last_pixel (i_last_pixel),
        .o_valid      (o_valid),
        .o_out_a      (o_out_a),
        .o_out_b      (o_out_b),
        .o_out_c      (o_out_c),
        .o_out_last   (o_out_last),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Formats as the block should hold them
    logic [1:0] src_fmt = FMT_RGB;
    logic [1:0] tgt_fmt = FMT_YCBCR;

    t_pixel_in  pixel_feed_q[$];
    t_pixel_res expected_px_q[$];
    int         queued_total = 0;
    int         accepted_total = 0;
    int         fail_cnt = 0;

    // Driver bookkeeping
    bit         in_taken = 1'b0;
    bit         have_next = 1'b0;
    int         idle_left = 0;
    t_pixel_in  next_px;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Limit to 0..255
    function automatic logic [7:0] sat_u8(input int v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Expected pixel for the given formats
    function automatic t_pixel_res convert_pixel(input logic [1:0] src, input logic [1:0] tgt,
                                                 input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c, input logic last);
        t_pixel_res r;
        int         va;
        int         vb;
        int         vc;
        int         y;
        va = int'(a);
        vb = int'(b);
        vc = int'(c);
        r.a = a;
        r.b = b;
        r.c = c;
        r.last = last;
        r.status = 1'b0;
        if (src == FMT_BAD || tgt == FMT_BAD) begin
            r.status = 1'b1;
        end else if (src == tgt) begin
            if (src == FMT_Y) begin
                r.b = 8'd0;
                r.c = 8'd0;
            end
        end else if (src == FMT_Y) begin
            r.status = 1'b1;
        end else if (src == FMT_RGB) begin
            y = int'(sat_u8((19595 * va + 38470 * vb + 7471 * vc) >>> 16));
            r.a = y[7:0];
            if (tgt == FMT_Y) begin
                r.b = 8'd0;
                r.c = 8'd0;
            end else begin
                r.b = sat_u8(((36962 * (vc - y)) >>> 16) + 128);
                r.c = sat_u8(((46727 * (va - y)) >>> 16) + 128);
            end
        end else begin
            // YCbCr source: grey keeps Y, RGB is reconstructed
            if (tgt == FMT_Y) begin
                r.b = 8'd0;
                r.c = 8'd0;
            end else begin
                r.a = sat_u8(va + ((91881 * vc) >>> 16) - 179);
                r.b = sat_u8(va - ((22544 * vb + 46793 * vc) >>> 16) + 135);
                r.c = sat_u8(va + ((116129 * vb) >>> 16) - 226);
            end
        end
        return r;
    endfunction

    task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: one pixel beat per item, with its drawn idle gap in front
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !in_taken)) begin
            if (!have_next && pixel_feed_q.size() > 0) begin
                next_px = pixel_feed_q.pop_front();
                have_next = 1'b1;
                idle_left = next_px.gap;
            end
            if (have_next && idle_left == 0) begin
                start <= 1'b1;
                i_comp_a <= next_px.a;
                i_comp_b <= next_px.b;
                i_comp_c <= next_px.c;
                i_last_pixel <= next_px.last;
                have_next = 1'b0;
            end else begin
                start <= 1'b0;
                if (have_next) begin
                    idle_left--;
                end
            end
        end
    end

    // Monitor: check results, predict each accepted beat
    always @(posedge i_clk) begin : mon
        t_pixel_res want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (expected_px_q.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %0d %0d %0d",
                             $time, o_out_a, o_out_b, o_out_c);
                    fail_cnt++;
                end else begin
                    want = expected_px_q.pop_front();
                    cmp_field("out_a", want.a, o_out_a);
                    cmp_field("out_b", want.b, o_out_b);
                    cmp_field("out_c", want.c, o_out_c);
                    cmp_field("out_last", {7'd0, want.last}, {7'd0, o_out_last});
                    cmp_field("status", {7'd0, want.status}, {7'd0, o_status});
                end
            end
            if (start && !busy) begin
                in_taken = 1'b1;
                accepted_total++;
                expected_px_q.push_back(convert_pixel(src_fmt, tgt_fmt, i_comp_a, i_comp_b,
                                                      i_comp_c, i_last_pixel));
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [1:0] fmt);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {30'd0, fmt};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_SRC) begin
            src_fmt = fmt;
        end else begin
            tgt_fmt = fmt;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [1:0] fmt);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {30'd0, fmt}) begin
            $display("%0t: register 0x%0h readback, expected %0d, actual %0d",
                     $time, addr, fmt, prdata);
            fail_cnt++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold off until every beat sent has come back
    task automatic wait_drained();
        while (accepted_total != queued_total || expected_px_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_formats(input logic [1:0] src, input logic [1:0] tgt);
        wait_drained();
        apb_write(ADDR_SRC, src);
        apb_write(ADDR_TGT, tgt);
        apb_read_check(ADDR_SRC, src);
        apb_read_check(ADDR_TGT, tgt);
    endtask

    task automatic queue_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                               input logic last, input int gap);
        t_pixel_in px;
        px.a = a;
        px.b = b;
        px.c = c;
        px.last = last;
        px.gap = gap;
        pixel_feed_q.push_back(px);
        queued_total++;
    endtask

    // Black, white, magenta, green corners: {last, a, b, c}
    task automatic queue_corners(input int n);
        logic [24:0] corner [4] = '{25'h0_000000, 25'h1_FFFFFF, 25'h0_FF00FF, 25'h1_00FF00};
        for (int k = 0; k < n; k++) begin
            queue_pixel(corner[k][23:16], corner[k][15:8], corner[k][7:0], corner[k][24], 0);
        end
    endtask

    // Random component, biased toward the rails to exercise clipping
    function automatic logic [7:0] rand_comp();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin : stim
        logic [1:0] src;
        logic [1:0] tgt;
        int         n;
        bit         no_idle;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset formats, then RGB to YCbCr corners, red and blue
        apb_read_check(ADDR_SRC, FMT_RGB);
        apb_read_check(ADDR_TGT, FMT_YCBCR);
        queue_corners(4);
        queue_pixel(8'd255, 8'd0, 8'd0, 1'b0, 0);
        queue_pixel(8'd0, 8'd0, 8'd255, 1'b0, 0);

        // YCbCr to RGB with chroma at both ends
        set_formats(FMT_YCBCR, FMT_RGB);
        queue_corners(4);
        queue_pixel(8'd128, 8'd128, 8'd128, 1'b0, 0);

        // Grey targets, identities, refused grey source, code 3
        set_formats(FMT_RGB, FMT_Y);
        queue_corners(2);
        set_formats(FMT_YCBCR, FMT_Y);
        queue_corners(2);
        set_formats(FMT_Y, FMT_Y);
        queue_corners(2);
        set_formats(FMT_YCBCR, FMT_YCBCR);
        queue_corners(1);
        set_formats(FMT_Y, FMT_RGB);
        queue_corners(2);
        set_formats(FMT_BAD, FMT_RGB);
        queue_corners(2);

        // Random phases: every format pair once, then a few drawn at random
        for (int i = 0; i < 20; i++) begin
            if (i < 16) begin
                src = i[3:2];
                tgt = i[1:0];
            end else begin
                src = 2'($urandom_range(0, 3));
                tgt = 2'($urandom_range(0, 3));
            end
            set_formats(src, tgt);
            n = $urandom_range(15, 35);
            no_idle = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < n; k++) begin
                queue_pixel(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 7) == 0,
                            no_idle ? 0 : $urandom_range(0, 9));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0 && expected_px_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rycc_pkg.sv
hdl/rgb_ycbcr_pixel_converter_top.sv
hdl/rycc_checker.sv
tb/rgb_ycbcr_pixel_converter_top_test.sv
